@@ rtl/core/tbcl_pkg.sv @@
package tbcl_pkg;

  // Fixed-point token scale: one token is TOKEN_SCALE units, one second is US_PER_SEC.
  localparam int unsigned TOKEN_SCALE = 1000000;
  localparam int unsigned US_PER_SEC  = 1000000;

  localparam int unsigned RATE_W    = 6;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned BUTTON_W  = 3;
  localparam int unsigned LEVEL_W   = 26;
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned INDEX_W   = 1;
  localparam int unsigned CFG_W     = 6;

  localparam logic [LEVEL_W-1:0] SCALE_UNITS = LEVEL_W'(TOKEN_SCALE);
  localparam logic [RATE_W-1:0]  RATE_RESET  = 6'd12;

  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd2;

  localparam logic [BUTTON_W-1:0] BTN_LEFT  = 3'd1;
  localparam logic [BUTTON_W-1:0] BTN_RIGHT = 3'd2;

  localparam logic [INDEX_W-1:0] REG_MAX_RATE    = 1'b0;
  localparam logic [INDEX_W-1:0] REG_TARGET_MODE = 1'b1;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;
  } cfg_write_t;

  typedef struct packed {
    logic allowed;
    logic counted_click;
  } result_t;

endpackage

@@ rtl/core/tbcl_in_stage.sv @@
module tbcl_in_stage #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_is_press,
  input  logic [tbcl_pkg::BUTTON_W-1:0]       in_button,
  input  logic [TIME_BITS-1:0]                in_timestamp,
  input  logic                                advance,
  output logic                                valid,
  output logic                                is_press,
  output logic [tbcl_pkg::BUTTON_W-1:0]       button,
  output logic [TIME_BITS-1:0]                timestamp_us
);

  // Take a new beat whenever the held one is empty or moves on this cycle.
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      is_press     <= in_is_press;
      button       <= in_button;
      timestamp_us <= in_timestamp;
    end
  end

endmodule

@@ rtl/core/tbcl_bucket.sv @@
module tbcl_bucket #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tbcl_pkg::cfg_write_t          cfg,
  input  logic                          fire,
  input  logic                          is_press,
  input  logic [tbcl_pkg::BUTTON_W-1:0] button,
  input  logic [TIME_BITS-1:0]          timestamp_us,
  output tbcl_pkg::result_t             result
);

  localparam int unsigned LW = tbcl_pkg::LEVEL_W;
  localparam int unsigned EW = tbcl_pkg::ELAPSED_W;
  localparam logic [TIME_BITS-1:0] SEC_US = TIME_BITS'(tbcl_pkg::US_PER_SEC);

  logic [tbcl_pkg::RATE_W-1:0] max_rate, max_rate_next;
  logic [tbcl_pkg::MODE_W-1:0] target_mode, target_mode_next;
  logic [LW-1:0]               token_level, token_level_next;
  logic [TIME_BITS-1:0]        last_time, last_time_next;
  logic                        started, started_next;

  logic [LW-1:0]        cap, cap_new, level_base, add, filled, level_cfg;
  logic [LW:0]          sum;
  logic [TIME_BITS-1:0] last_base, elapsed;
  logic                 targeted;

  assign cap     = LW'(max_rate) * tbcl_pkg::SCALE_UNITS;
  assign cap_new = LW'(cfg.data[tbcl_pkg::RATE_W-1:0]) * tbcl_pkg::SCALE_UNITS;

  // First press fills the bucket and stamps the time.
  assign level_base = started ? token_level : cap;
  assign last_base  = started ? last_time : timestamp_us;
  assign elapsed    = timestamp_us - last_base;

  assign add    = LW'(elapsed[EW-1:0]) * LW'(max_rate);
  assign sum    = {1'b0, level_base} + {1'b0, add};
  assign filled = (elapsed >= SEC_US || sum > {1'b0, cap}) ? cap : sum[LW-1:0];

  assign level_cfg = (token_level > cap_new) ? cap_new : token_level;

  assign targeted =
    ((target_mode == tbcl_pkg::MODE_LEFT || target_mode == tbcl_pkg::MODE_BOTH) &&
     button == tbcl_pkg::BTN_LEFT) ||
    ((target_mode == tbcl_pkg::MODE_RIGHT || target_mode == tbcl_pkg::MODE_BOTH) &&
     button == tbcl_pkg::BTN_RIGHT);

  always_comb begin
    max_rate_next    = max_rate;
    target_mode_next = target_mode;
    token_level_next = token_level;
    last_time_next   = last_time;
    started_next     = started;
    result.allowed       = 1'b1;
    result.counted_click = 1'b0;

    if (fire) begin
      if (is_press) begin
        started_next     = 1'b1;
        token_level_next = level_base;
        last_time_next   = last_base;
        if (targeted) begin
          if (max_rate == '0) begin
            result.counted_click = 1'b1;
          end else begin
            last_time_next = timestamp_us;
            if (filled >= tbcl_pkg::SCALE_UNITS) begin
              token_level_next     = filled - tbcl_pkg::SCALE_UNITS;
              result.counted_click = 1'b1;
            end else begin
              token_level_next = filled;
              result.allowed   = 1'b0;
            end
          end
        end
      end
    end else if (cfg.en) begin
      case (cfg.index)
        tbcl_pkg::REG_MAX_RATE: begin
          max_rate_next    = cfg.data[tbcl_pkg::RATE_W-1:0];
          token_level_next = level_cfg;
        end
        tbcl_pkg::REG_TARGET_MODE: begin
          target_mode_next = cfg.data[tbcl_pkg::MODE_W-1:0];
        end
        default: begin
          target_mode_next = target_mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate    <= tbcl_pkg::RATE_RESET;
      target_mode <= tbcl_pkg::MODE_LEFT;
      token_level <= '0;
      last_time   <= '0;
      started     <= 1'b0;
    end else begin
      max_rate    <= max_rate_next;
      target_mode <= target_mode_next;
      token_level <= token_level_next;
      last_time   <= last_time_next;
      started     <= started_next;
    end
  end

  a_level_within_cap: assert property (@(posedge clk) disable iff (rst)
    token_level <= cap)
    else $error("token level above capacity");

  a_idle_bucket_empty: assert property (@(posedge clk) disable iff (rst)
    !started |-> token_level == '0)
    else $error("bucket holds tokens before first press");

  a_count_needs_pass: assert property (@(posedge clk) disable iff (rst)
    fire && result.counted_click |-> result.allowed)
    else $error("counted click on a cancelled event");

  a_cancel_takes_time: assert property (@(posedge clk) disable iff (rst)
    fire && !result.allowed |=> last_time == $past(timestamp_us))
    else $error("cancelled press did not advance last time");

endmodule

@@ rtl/core/token_bucket_click_limiter.sv @@
// Channel   Dir  Fields (tdata / tuser, lowest bit up)
// s_*       in   tdata: button[2:0], timestamp_us[TIME_BITS-1:0], zero pad; tuser: is_press
// m_*       out  tdata: allowed, zero pad; tuser: counted_click
// write_*   in   write_index selects max_rate (0) or target_mode (1), write_data 6 bits
//
// One beat per cycle sustained while m_tready stays high; a beat taken on s_* passes
// through the input register and then the output register before it shows on m_*.
// The bucket decision is one pass of refill multiply, saturate and compare
// between the input register and the output register, so back-to-back beats
// see the state left by the one before.
// Reset clears the bucket, the start flag and both valid stages; max_rate
// comes up at 12 and target_mode at left.
// A stall on m_tready holds the output beat and the input stage behind it.
module token_bucket_click_limiter #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // button[2:0], timestamp_us[TIME_BITS+2:3], zero pad
  input  logic [((TIME_BITS+10)/8)*8-1:0]  s_tdata,
  // is_press
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // allowed[0], zero pad
  output logic [7:0]                       m_tdata,
  // counted_click
  output logic                             m_tuser,
  input  logic                             write_en,
  input  logic [tbcl_pkg::INDEX_W-1:0]     write_index,
  input  logic [tbcl_pkg::CFG_W-1:0]       write_data
);

  localparam int unsigned BW = tbcl_pkg::BUTTON_W;

  logic                 advance, fire;
  logic                 hold_valid, hold_press;
  logic [BW-1:0]        hold_button;
  logic [TIME_BITS-1:0] hold_time;
  tbcl_pkg::cfg_write_t cfg;
  tbcl_pkg::result_t    result, result_q;

  // Move the held beat on whenever the output slot is free or drains.
  assign advance = !m_tvalid || m_tready;
  assign fire    = hold_valid && advance;

  assign cfg.en    = write_en;
  assign cfg.index = write_index;
  assign cfg.data  = write_data;

  tbcl_in_stage #(.TIME_BITS(TIME_BITS)) u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_is_press  (s_tuser),
    .in_button    (s_tdata[BW-1:0]),
    .in_timestamp (s_tdata[TIME_BITS+BW-1:BW]),
    .advance      (advance),
    .valid        (hold_valid),
    .is_press     (hold_press),
    .button       (hold_button),
    .timestamp_us (hold_time)
  );

  tbcl_bucket #(.TIME_BITS(TIME_BITS)) u_bucket (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (fire),
    .is_press     (hold_press),
    .button       (hold_button),
    .timestamp_us (hold_time),
    .result       (result)
  );

  // Output register: load on fire, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign m_tdata = {7'b0, result_q.allowed};
  assign m_tuser = result_q.counted_click;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// Click limiter testbench.
// Events go in on the s_* stream and one verdict per event comes back on m_*.
// A behavioral token bucket runs beside the block: every beat taken on the
// input side is scored right away, and the verdict is queued until the block
// hands its own verdict back. Registers are rewritten only once the block is
// drained. The sender runs in bursts with random gaps. The receiver stalls
// on several patterns, and once holds off long enough to back up the
// pipeline and stall the input.
module testbench;

  localparam int TS_W = 40;
  localparam int SDATA_W = ((TS_W + 10) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_QUOTA = 46;

  // target_mode code that targets no button at all
  localparam logic [tbcl_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

  localparam logic [TS_W-1:0] STAMP_MAX = {TS_W{1'b1}};

  // receiver stall styles
  localparam int READY_ALWAYS = 0;
  localparam int READY_RANDOM = 1;
  localparam int READY_PATTERN = 2;

  // ready pattern, one bit per cycle
  localparam logic [7:0] READY_MASK = 8'b1101_0110;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_tvalid = 1'b0;
  logic s_tready;
  // button[2:0], timestamp_us[42:3], zero pad
  logic [SDATA_W-1:0] s_tdata = '0;
  // is_press
  logic s_tuser = 1'b0;

  logic m_tvalid;
  logic m_tready = 1'b0;
  // allowed[0], zero pad
  logic [7:0] m_tdata;
  // counted_click
  logic m_tuser;

  logic write_en = 1'b0;
  logic [tbcl_pkg::INDEX_W-1:0] write_index = '0;
  logic [tbcl_pkg::CFG_W-1:0] write_data = '0;

  token_bucket_click_limiter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bucket state mirrored beside the block
  logic [tbcl_pkg::RATE_W-1:0] rate_reg = tbcl_pkg::RATE_RESET;
  logic [tbcl_pkg::MODE_W-1:0] mode_reg = tbcl_pkg::MODE_LEFT;
  longint unsigned bucket_level = 0;
  logic [TS_W-1:0] bucket_stamp = '0;
  bit bucket_live = 1'b0;

  tbcl_pkg::result_t pending_verdicts[$];
  int mismatches = 0;

  // sender and receiver knobs, written by the tasks and the initial block only
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int ready_style = READY_ALWAYS;
  int hold_req = 0;

  // receiver's own bookkeeping
  int hold_ack = 0;
  int hold_left = 0;
  logic [2:0] pattern_phase = '0;

  logic [TS_W-1:0] stamp_now = '0;

  function automatic longint unsigned capacity_units();
    return longint'(rate_reg) * tbcl_pkg::TOKEN_SCALE;
  endfunction

  // Score one event against the bucket and advance the bucket.
  function automatic tbcl_pkg::result_t bucket_decision(bit press,
                                                        logic [tbcl_pkg::BUTTON_W-1:0] btn,
                                                        logic [TS_W-1:0] ts);
    tbcl_pkg::result_t verdict;
    bit hit;
    logic [TS_W-1:0] elapsed;
    longint unsigned cap;
    verdict.allowed = 1'b1;
    verdict.counted_click = 1'b0;
    if (!press) return verdict;
    cap = capacity_units();
    // any first press fills the bucket, targeted or not
    if (!bucket_live) begin
      bucket_live = 1'b1;
      bucket_level = cap;
      bucket_stamp = ts;
    end
    hit = ((mode_reg == tbcl_pkg::MODE_LEFT || mode_reg == tbcl_pkg::MODE_BOTH) &&
           btn == tbcl_pkg::BTN_LEFT) ||
          ((mode_reg == tbcl_pkg::MODE_RIGHT || mode_reg == tbcl_pkg::MODE_BOTH) &&
           btn == tbcl_pkg::BTN_RIGHT);
    if (!hit) return verdict;
    // unlimited: count the click, leave the bucket alone
    if (rate_reg == 0) begin
      verdict.counted_click = 1'b1;
      return verdict;
    end
    elapsed = ts - bucket_stamp;
    bucket_stamp = ts;
    if (elapsed >= tbcl_pkg::US_PER_SEC) begin
      bucket_level = cap;
    end else begin
      bucket_level += (longint'(elapsed) * rate_reg * tbcl_pkg::TOKEN_SCALE) /
                      tbcl_pkg::US_PER_SEC;
      if (bucket_level > cap) bucket_level = cap;
    end
    if (bucket_level >= tbcl_pkg::TOKEN_SCALE) begin
      bucket_level -= tbcl_pkg::TOKEN_SCALE;
      verdict.counted_click = 1'b1;
    end else begin
      verdict.allowed = 1'b0;
    end
    return verdict;
  endfunction

  // Offer one event and hold it until the block takes it. Called just after
  // a rising edge; returns just after the edge that took the beat, with
  // s_tvalid still high.
  task automatic send_event(bit press, logic [tbcl_pkg::BUTTON_W-1:0] btn,
                            logic [TS_W-1:0] ts);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= press;
    s_tdata <= {{(SDATA_W - TS_W - tbcl_pkg::BUTTON_W){1'b0}}, ts, btn};
    // handshake lines are stable from the falling edge to the next rising one
    do @(negedge clk); while (!s_tready);
    pending_verdicts.push_back(bucket_decision(press, btn, ts));
    @(posedge clk);
  endtask

  // Drop valid and wait until every verdict is back and the pipe is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(logic [tbcl_pkg::INDEX_W-1:0] index,
                              logic [tbcl_pkg::CFG_W-1:0] value);
    drain();
    write_en <= 1'b1;
    write_index <= index;
    write_data <= value;
    @(posedge clk);
    write_en <= 1'b0;
    if (index == tbcl_pkg::REG_MAX_RATE) begin
      rate_reg = value;
      if (bucket_level > capacity_units()) bucket_level = capacity_units();
      if (rate_reg == 0) bucket_level = 0;
    end else begin
      mode_reg = value[tbcl_pkg::MODE_W-1:0];
    end
  endtask

  // Reset settings: release before start, untargeted first press, wrapped stamp
  task automatic test_start_and_wrap();
    send_event(1'b0, tbcl_pkg::BTN_LEFT, '0);
    send_event(1'b1, 3'd7, STAMP_MAX - 40'd15);
    send_event(1'b1, tbcl_pkg::BTN_RIGHT, '0);
    // elapsed wraps through zero: 21 us
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd5);
  endtask

  // Rate one: clamp on write, run dry, refill by the microsecond, clock going back
  task automatic test_drain_refill();
    set_register(tbcl_pkg::REG_MAX_RATE, 6'd1);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd5);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd5);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd1_000_004);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd1_000_005);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd3);
  endtask

  task automatic test_unlimited_rate();
    set_register(tbcl_pkg::REG_MAX_RATE, 6'd0);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, '0);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, STAMP_MAX);
    send_event(1'b0, tbcl_pkg::BTN_RIGHT, STAMP_MAX);
  endtask

  // Largest rate with both buttons, then no target, then right only
  task automatic test_modes();
    set_register(tbcl_pkg::REG_MAX_RATE, 6'd63);
    set_register(tbcl_pkg::REG_TARGET_MODE, tbcl_pkg::MODE_BOTH);
    send_event(1'b1, tbcl_pkg::BTN_RIGHT, 40'd2_000_000);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd2_000_000);
    send_event(1'b1, 3'd4, 40'd2_000_001);
    send_event(1'b1, 3'd0, 40'd2_000_002);
    set_register(tbcl_pkg::REG_TARGET_MODE, MODE_NONE);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd2_000_003);
    send_event(1'b1, tbcl_pkg::BTN_RIGHT, 40'd2_000_004);
    set_register(tbcl_pkg::REG_TARGET_MODE, tbcl_pkg::MODE_RIGHT);
    send_event(1'b1, tbcl_pkg::BTN_LEFT, 40'd2_000_005);
    send_event(1'b1, tbcl_pkg::BTN_RIGHT, 40'd2_000_006);
  endtask

  // One random event. Mostly presses on limited buttons at a pace near the
  // bucket's rate, with some bursts, long pauses, stamps thrown anywhere and
  // steps back in time.
  task automatic random_event(int spacing, output bit counted);
    bit press;
    logic [tbcl_pkg::BUTTON_W-1:0] btn;
    int pick;
    int unsigned raw;
    press = $urandom_range(0, 99) < 70;
    pick = $urandom_range(0, 9);
    raw = $urandom_range(0, 7);
    if (pick < 4) btn = tbcl_pkg::BTN_LEFT;
    else if (pick < 7) btn = tbcl_pkg::BTN_RIGHT;
    else btn = raw[tbcl_pkg::BUTTON_W-1:0];
    pick = $urandom_range(0, 99);
    raw = $urandom_range(0, 255);
    if (pick < 50) stamp_now += TS_W'($urandom_range(0, 2 * spacing));
    else if (pick < 80) stamp_now += TS_W'($urandom_range(0, 200));
    else if (pick < 92) stamp_now += TS_W'($urandom_range(0, 1_500_000));
    else if (pick < 96) stamp_now = {raw[7:0], $urandom};
    else stamp_now -= TS_W'($urandom_range(1, 5000));
    send_event(press, btn, stamp_now);
    counted = press && (btn == tbcl_pkg::BTN_LEFT || btn == tbcl_pkg::BTN_RIGHT);
  endtask

  task automatic test_random_traffic();
    logic [tbcl_pkg::RATE_W-1:0] rate;
    logic [tbcl_pkg::MODE_W-1:0] mode;
    int presses;
    int spacing;
    bit counted;
    int unsigned raw;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin rate = 6'd12; mode = tbcl_pkg::MODE_LEFT; end
        1: begin rate = 6'd50; mode = tbcl_pkg::MODE_BOTH; end
        2: begin rate = 6'd1; mode = tbcl_pkg::MODE_RIGHT; end
        3: begin rate = 6'd0; mode = tbcl_pkg::MODE_BOTH; end
        4: begin rate = 6'd63; mode = tbcl_pkg::MODE_BOTH; end
        5: begin rate = 6'd3; mode = tbcl_pkg::MODE_LEFT; end
        6: begin rate = 6'd2; mode = MODE_NONE; end
        default: begin
          raw = $urandom_range(0, 63);
          rate = raw[tbcl_pkg::RATE_W-1:0];
          raw = $urandom_range(0, 3);
          mode = raw[tbcl_pkg::MODE_W-1:0];
        end
      endcase
      set_register(tbcl_pkg::REG_MAX_RATE, rate);
      set_register(tbcl_pkg::REG_TARGET_MODE, mode);
      ready_style = phase % 3;
      // one phase runs flat out on both sides
      gaps_on = (phase != 4);
      if (phase == 4) ready_style = READY_ALWAYS;
      spacing = (rate == 0) ? 1000 : 1_000_000 / rate;
      presses = 0;
      while (presses < PHASE_QUOTA) begin
        random_event(spacing, counted);
        if (counted) presses++;
      end
    end
  endtask

  // Hold the output off while the sender keeps offering, so the block backs up.
  task automatic test_output_holdoff();
    bit counted;
    set_register(tbcl_pkg::REG_MAX_RATE, 6'd5);
    set_register(tbcl_pkg::REG_TARGET_MODE, tbcl_pkg::MODE_BOTH);
    gaps_on = 1'b0;
    ready_style = READY_ALWAYS;
    hold_req++;
    repeat (30) random_event(200_000, counted);
    gaps_on = 1'b1;
    ready_style = READY_RANDOM;
    repeat (30) random_event(200_000, counted);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    ready_style = READY_RANDOM;
    test_start_and_wrap();
    test_drain_refill();
    test_unlimited_rate();
    ready_style = READY_PATTERN;
    test_modes();
    test_random_traffic();
    test_output_holdoff();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: long hold-off on request, otherwise the current stall style.
  always @(posedge clk) begin
    pattern_phase = pattern_phase + 3'd1;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (ready_style)
        READY_RANDOM: m_tready <= $urandom_range(0, 99) >= 35;
        READY_PATTERN: m_tready <= READY_MASK[pattern_phase];
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Score each verdict beat against the oldest queued one.
  always @(negedge clk) begin
    tbcl_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: verdict with none pending: allowed %0b counted_click %0b",
                 $time, m_tdata[0], m_tuser);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[0] !== want.allowed) begin
          mismatches++;
          $display("%0t: allowed expected %0b actual %0b", $time, want.allowed, m_tdata[0]);
        end
        if (m_tuser !== want.counted_click) begin
          mismatches++;
          $display("%0t: counted_click expected %0b actual %0b",
                   $time, want.counted_click, m_tuser);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int quiet_cycles = 0;
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

@@ token_bucket_click_limiter.f @@
rtl/core/tbcl_pkg.sv
rtl/core/tbcl_in_stage.sv
rtl/core/tbcl_bucket.sv
rtl/core/token_bucket_click_limiter.sv
test/testbench.sv
